// ----- hdl/assert_macros.svh -----
// Assertion macros for the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on a given clock, disabled while the active-low reset is low.
`define SITDA_ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("sitda assertion failed");

// Assert a property on the default clock and reset of this project.
`define SITDA_ASSERT(lbl, prop) \
  `SITDA_ASSERT_AT(lbl, clk_i, rst_ni, prop)

`endif

// ----- hdl/sitda_pkg.sv -----
// Types and constants shared by the signed integer to decimal text block.
`timescale 1ns / 1ps
`default_nettype none

package sitda_pkg;

  localparam int unsigned MagW      = 32;
  localparam int unsigned CharW     = 8;
  localparam int unsigned DigW      = 4;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned BcdW      = DigW * NumDigits;
  localparam int unsigned DigIdxW   = 4;
  localparam int unsigned StepCntW  = 5;

  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharNine  = 8'h39;
  localparam logic [CharW-1:0] CharMinus = 8'h2D;

  localparam logic [DigW-1:0] BcdAdjMin = 4'd5;
  localparam logic [DigW-1:0] BcdAdjAdd = 4'd3;

  // One classified number: sign and unsigned magnitude.
  typedef struct packed {
    logic            neg;
    logic [MagW-1:0] mag;
  } item_t;

  // Queue status seen by the front and back parts.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

`default_nettype wire

// ----- hdl/sitda_front.sv -----
// Front part: accepts a number and splits it into sign and unsigned magnitude.
`timescale 1ns / 1ps
`default_nettype none

module sitda_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic signed [sitda_pkg::MagW-1:0] value_i,
  output logic                             busy_o,
  input  wire sitda_pkg::fifo_stat_t       fifo_stat_i,
  output logic                             push_o,
  output sitda_pkg::item_t                 item_o
);

  logic             valid_q, valid_d;
  sitda_pkg::item_t item_q;
  logic             accept;
  logic [sitda_pkg::MagW-1:0] raw;

  assign raw    = unsigned'(value_i);
  assign busy_o = valid_q && fifo_stat_i.full;
  assign push_o = valid_q && !fifo_stat_i.full;
  assign accept = start_i && !busy_o;
  assign item_o = item_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Negate in unsigned arithmetic so the most negative value keeps its magnitude.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.neg <= raw[sitda_pkg::MagW-1];
      item_q.mag <= raw[sitda_pkg::MagW-1] ? (sitda_pkg::MagW'(0) - raw) : raw;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sitda_fifo.sv -----
// Short queue of classified numbers between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none

module sitda_fifo #(
  parameter int unsigned Depth = 2
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire sitda_pkg::item_t  item_i,
  input  wire logic              pop_i,
  output sitda_pkg::item_t       item_o,
  output sitda_pkg::fifo_stat_t  stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  sitda_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == CntFull);
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sitda_back.sv -----
// Back part: double-dabble conversion and character serializer.
`timescale 1ns / 1ps
`default_nettype none

module sitda_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire sitda_pkg::fifo_stat_t        fifo_stat_i,
  input  wire sitda_pkg::item_t             item_i,
  output logic                              pop_o,
  output logic                              char_valid_o,
  output logic [sitda_pkg::CharW-1:0]       char_code_o,
  output logic                              last_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  localparam logic [sitda_pkg::StepCntW-1:0] StepLast =
    sitda_pkg::StepCntW'(sitda_pkg::MagW - 1);

  logic [1:0]                       state_q, state_d;
  logic [sitda_pkg::StepCntW-1:0]   step_q, step_d;
  logic [sitda_pkg::DigIdxW-1:0]    dig_q, dig_d;
  logic                             neg_q, neg_d;
  logic                             lead_q, lead_d;
  logic [sitda_pkg::MagW-1:0]       shift_q, shift_d;
  logic [sitda_pkg::BcdW-1:0]       bcd_q, bcd_d, bcd_adj;
  logic [sitda_pkg::DigIdxW-1:0]    msd, cur_idx;
  logic [sitda_pkg::DigW-1:0]       cur_dig;
  logic                             out_valid_q, out_valid_d;
  logic [sitda_pkg::CharW-1:0]      out_char_q, out_char_d;
  logic                             out_last_q, out_last_d;

  assign pop_o        = (state_q == StIdle) && !fifo_stat_i.empty;
  assign char_valid_o = out_valid_q;
  assign char_code_o  = out_char_q;
  assign last_o       = out_last_q;

  // Add three to every BCD digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < sitda_pkg::NumDigits; i++) begin
      if (bcd_q[i*sitda_pkg::DigW +: sitda_pkg::DigW] >= sitda_pkg::BcdAdjMin) begin
        bcd_adj[i*sitda_pkg::DigW +: sitda_pkg::DigW] =
          bcd_q[i*sitda_pkg::DigW +: sitda_pkg::DigW] + sitda_pkg::BcdAdjAdd;
      end else begin
        bcd_adj[i*sitda_pkg::DigW +: sitda_pkg::DigW] =
          bcd_q[i*sitda_pkg::DigW +: sitda_pkg::DigW];
      end
    end
  end

  // Most significant nonzero digit; zero for the value zero.
  always_comb begin
    msd = '0;
    for (int i = 0; i < sitda_pkg::NumDigits; i++) begin
      if (bcd_q[i*sitda_pkg::DigW +: sitda_pkg::DigW] != '0) begin
        msd = sitda_pkg::DigIdxW'(i);
      end
    end
  end

  assign cur_idx = lead_q ? msd : dig_q;

  always_comb begin
    cur_dig = '0;
    for (int i = 0; i < sitda_pkg::NumDigits; i++) begin
      if (cur_idx == sitda_pkg::DigIdxW'(i)) begin
        cur_dig = bcd_q[i*sitda_pkg::DigW +: sitda_pkg::DigW];
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    dig_d       = dig_q;
    neg_d       = neg_q;
    lead_d      = lead_q;
    shift_d     = shift_q;
    bcd_d       = bcd_q;
    out_valid_d = 1'b0;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    unique case (state_q)
      StIdle: begin
        if (pop_o) begin
          shift_d = item_i.mag;
          neg_d   = item_i.neg;
          bcd_d   = '0;
          step_d  = '0;
          state_d = StConv;
        end
      end
      StConv: begin
        bcd_d   = {bcd_adj[sitda_pkg::BcdW-2:0], shift_q[sitda_pkg::MagW-1]};
        shift_d = {shift_q[sitda_pkg::MagW-2:0], 1'b0};
        step_d  = step_q + sitda_pkg::StepCntW'(1);
        if (step_q == StepLast) begin
          lead_d  = 1'b1;
          state_d = StEmit;
        end
      end
      StEmit: begin
        out_valid_d = 1'b1;
        if (neg_q) begin
          out_char_d = sitda_pkg::CharMinus;
          out_last_d = 1'b0;
          neg_d      = 1'b0;
        end else begin
          out_char_d = sitda_pkg::CharZero + {{(sitda_pkg::CharW - sitda_pkg::DigW){1'b0}},
                                              cur_dig};
          out_last_d = (cur_idx == '0);
          lead_d     = 1'b0;
          dig_d      = cur_idx - sitda_pkg::DigIdxW'(1);
          if (cur_idx == '0) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      dig_q       <= '0;
      neg_q       <= 1'b0;
      lead_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      dig_q       <= dig_d;
      neg_q       <= neg_d;
      lead_q      <= lead_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q    <= shift_d;
    bcd_q      <= bcd_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

endmodule

`default_nettype wire

// ----- hdl/signed_int_to_decimal_ascii_core.sv -----
// Top level: signed 32-bit integer to decimal ASCII text.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+--------------------------
//  number  | in        | start high, busy low       | value_i (32-bit signed)
//  text    | out       | char_valid_o strobe, 1 cyc | char_code_o, last_o
//
// Each number passes through the converter in steps: a pop from the queue,
// double-dabble shifting (one magnitude bit per cycle), then one character
// per cycle, 1 to 11 characters in all. The front register and the queue
// soak up numbers meanwhile; busy rises only when both are full. Reset is
// asynchronous and active low and clears all control state; nothing needs a
// clearing pass. The receiver cannot stall: every character is a one-cycle
// strobe.
`timescale 1ns / 1ps
`default_nettype none

module signed_int_to_decimal_ascii_core #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  input  wire logic signed [sitda_pkg::MagW-1:0]  value_i,
  output logic                                    busy,
  output logic                                    char_valid_o,
  output logic [sitda_pkg::CharW-1:0]             char_code_o,
  output logic                                    last_o
);

  sitda_pkg::fifo_stat_t fifo_stat;
  sitda_pkg::item_t      front_item;
  sitda_pkg::item_t      back_item;
  logic                  push;
  logic                  pop;

  // Accept a transaction and classify it: sign plus unsigned magnitude.
  sitda_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .value_i     (value_i),
    .busy_o      (busy),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .item_o      (front_item)
  );

  // Hold classified numbers while the converter works on an earlier one.
  sitda_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .pop_i  (pop),
    .item_o (back_item),
    .stat_o (fifo_stat)
  );

  // Convert to BCD, then drop leading zeros and stream the characters.
  sitda_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_stat_i  (fifo_stat),
    .item_i       (back_item),
    .pop_o        (pop),
    .char_valid_o (char_valid_o),
    .char_code_o  (char_code_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

// ----- hdl/sitda_checker.sv -----
// Port-level checks for the decimal text converter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sitda_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               start,
  input wire logic                               busy,
  input wire logic [sitda_pkg::CharW-1:0]        char_code_o,
  input wire logic                               char_valid_o,
  input wire logic                               last_o
);

  logic is_minus;
  logic is_digit;
  logic is_lead;

  assign is_minus = (char_code_o == sitda_pkg::CharMinus);
  assign is_digit = (char_code_o >= sitda_pkg::CharZero) &&
                    (char_code_o <= sitda_pkg::CharNine);
  assign is_lead  = is_digit && (char_code_o != sitda_pkg::CharZero);

  `SITDA_ASSERT(a_char_legal, char_valid_o |-> (is_minus || is_digit))
  `SITDA_ASSERT(a_minus_not_last, (char_valid_o && is_minus) |-> !last_o)
  `SITDA_ASSERT(a_minus_then_lead, (char_valid_o && is_minus) |=> (char_valid_o && is_lead))
  `SITDA_ASSERT(a_text_unbroken, (char_valid_o && !last_o) |=> char_valid_o)
  // A held transaction is taken once the converter finishes the number it works on.
  `SITDA_ASSERT(a_busy_bounded, (start && busy) |-> ##[1:48] !busy)

endmodule

bind signed_int_to_decimal_ascii_core sitda_checker u_sitda_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .char_code_o  (char_code_o),
  .char_valid_o (char_valid_o),
  .last_o       (last_o)
);

`default_nettype wire
